### rtl/core/cav_pkg.sv
// ----------------------------------------------------------------------------
// cav_pkg
// Shared widths and limits for the closest-approach-to-vertex block.
// ----------------------------------------------------------------------------
package cav_pkg;

  localparam int POS_WIDTH_DEF = 20;
  localparam int MOM_WIDTH_DEF = 18;

  localparam int TR_WIDTH   = 21;
  localparam int LG_WIDTH   = 22;
  localparam int ROOT_WIDTH = 22;

  localparam logic [TR_WIDTH-1:0] TR_MAX     = 21'h1FFFFF;
  localparam logic [LG_WIDTH-1:0] LG_MAX     = 22'h1FFFFF;
  localparam logic [LG_WIDTH:0]   LG_MIN_MAG = 23'h200000;

endpackage

### rtl/core/cav_if.sv
// ----------------------------------------------------------------------------
// cav_in_if / cav_out_if
// Valid/ready channels carrying one track item and one distance result.
// ----------------------------------------------------------------------------
interface cav_in_if #(
  parameter int PW = cav_pkg::POS_WIDTH_DEF,
  parameter int MW = cav_pkg::MOM_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [PW-1:0] point_x;
  logic signed [PW-1:0] point_y;
  logic signed [PW-1:0] point_z;
  logic signed [MW-1:0] mom_x;
  logic signed [MW-1:0] mom_y;
  logic signed [MW-1:0] mom_z;
  logic signed [PW-1:0] vertex_x;
  logic signed [PW-1:0] vertex_y;
  logic signed [PW-1:0] vertex_z;

  modport source (output valid, point_x, point_y, point_z, mom_x, mom_y, mom_z,
                  vertex_x, vertex_y, vertex_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, mom_x, mom_y, mom_z,
                vertex_x, vertex_y, vertex_z, output ready);
endinterface

interface cav_out_if;
  logic                                  valid;
  logic                                  ready;
  logic        [cav_pkg::TR_WIDTH-1:0]   dist_transverse;
  logic signed [cav_pkg::LG_WIDTH-1:0]   dist_longitudinal;
  logic                                  zero_momentum;

  modport source (output valid, dist_transverse, dist_longitudinal, zero_momentum,
                  input ready);
  modport sink (input valid, dist_transverse, dist_longitudinal, zero_momentum,
                output ready);
endinterface

### rtl/core/cav_div.sv
// ----------------------------------------------------------------------------
// cav_div
// Pipelined restoring divider, one quotient bit per stage, rounded to nearest
// with ties up. The quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module cav_div #(
  parameter int NW = 36,
  parameter int QW = 21
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NW+QW-1:0] u,
  input  logic [NW-1:0]    n,
  output logic [QW:0]      q
);
  localparam int UW = NW + QW;

  logic [NW-1:0] rem  [0:QW];
  logic [QW-1:0] low  [0:QW];
  logic [QW-1:0] quo  [0:QW];
  logic [NW-1:0] den  [0:QW];
  logic          rnd;

  // load the upper part of the dividend as the first partial remainder
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= u[UW-1:QW];
      low[0] <= u[QW-1:0];
      quo[0] <= '0;
      den[0] <= n;
    end
  end

  // one trial subtraction per stage
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [NW:0] trial;
    logic [NW:0] diff;
    logic        ge;

    assign trial = {rem[k], low[k][QW-1]};
    assign diff  = trial - {1'b0, den[k]};
    assign ge    = trial >= {1'b0, den[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[NW-1:0] : trial[NW-1:0];
        low[k+1] <= low[k] << 1;
        quo[k+1] <= {quo[k][QW-2:0], ge};
        den[k+1] <= den[k];
      end
    end
  end

  // round up when the remainder is at least half the divisor
  assign rnd = rem[QW] >= (den[QW] - rem[QW]);

  always_ff @(posedge clk) begin
    if (en) begin
      q <= {1'b0, quo[QW]} + (QW+1)'(rnd);
    end
  end

endmodule

### rtl/core/cav_sqrt.sv
// ----------------------------------------------------------------------------
// cav_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage,
// rounded down.
// ----------------------------------------------------------------------------
module cav_sqrt #(
  parameter int RW = 22
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] s,
  output logic [RW-1:0]   root
);
  localparam int SW = 2 * RW;

  logic [RW+1:0] rem [0:RW];
  logic [RW-1:0] rt  [0:RW];
  logic [SW-1:0] sv  [0:RW];

  // clear remainder and root, take the radicand
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      rt[0]  <= '0;
      sv[0]  <= s;
    end
  end

  // bring down two radicand bits and try the next root bit
  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [RW+3:0] cur;
    logic [RW+3:0] trial;
    logic [RW+3:0] diff;
    logic          ge;

    assign cur   = {rem[k], sv[k][SW-1:SW-2]};
    assign trial = {2'b00, rt[k], 2'b01};
    assign diff  = cur - trial;
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[RW+1:0] : cur[RW+1:0];
        rt[k+1]  <= {rt[k][RW-2:0], ge};
        sv[k+1]  <= sv[k] << 2;
      end
    end
  end

  assign root = rt[RW];

endmodule

### rtl/core/closest_approach_to_vertex_top.sv
// ----------------------------------------------------------------------------
// closest_approach_to_vertex_top
// Distance of closest approach of a straight track to a vertex.
// ----------------------------------------------------------------------------
// Usage:
//   trk carries one item per transfer: track point, momentum and vertex.
//   res carries one result per item: transverse distance (floor of root),
//   longitudinal offset vertex z minus closest point z, and a zero-momentum
//   flag that forces both distances to zero. Both distances saturate.
// Throughput: one item per cycle while res.ready is high.
// Pipeline: each divider (one quotient bit per stage, POS_WIDTH + 3 stages)
//   and the square root (one root bit per stage, 23 stages) plus ten
//   further stages: six ahead of the dividers, three between the dividers
//   and the root, and the output.
// Reset: synchronous; empties the pipeline, res.valid drops the next cycle.
// Stall: when res holds a result that is not taken, the whole pipeline
//   freezes and trk.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module closest_approach_to_vertex_top #(
  parameter int POS_WIDTH = cav_pkg::POS_WIDTH_DEF,
  parameter int MOM_WIDTH = cav_pkg::MOM_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  cav_in_if.sink    trk,
  cav_out_if.source res
);
  import cav_pkg::*;

  localparam int CW  = POS_WIDTH + 1;
  localparam int CM  = CW + MOM_WIDTH;
  localparam int NW  = 2 * MOM_WIDTH;
  localparam int DW  = POS_WIDTH + MOM_WIDTH + 2;
  localparam int EW  = POS_WIDTH + 2 * MOM_WIDTH + 2;
  localparam int UW  = EW - 1;
  localparam int QW  = POS_WIDTH + 1;
  localparam int DL  = QW + 2;
  localparam int SL  = ROOT_WIDTH + 1;
  localparam int ZW  = (QW + 1 > LG_WIDTH + 1) ? QW + 1 : LG_WIDTH + 1;
  localparam int L   = 10 + DL + SL;
  localparam int SQW = 2 * TR_WIDTH;

  logic         en;
  logic [L-1:0] vld;

  logic signed [POS_WIDTH-1:0] pin [3];
  logic signed [POS_WIDTH-1:0] vin [3];
  logic signed [MOM_WIDTH-1:0] min [3];

  logic signed [CW-1:0]        ca [3];
  logic signed [MOM_WIDTH-1:0] ma [3];
  logic signed [CM-1:0]        cmb [3];
  logic        [NW-1:0]        mmb [3];
  logic signed [CW-1:0]        cb [3];
  logic signed [MOM_WIDTH-1:0] mb [3];
  logic signed [DW-1:0]        dotc;
  logic        [NW-1:0]        nc;
  logic                        zc;
  logic signed [CW-1:0]        cc [3];
  logic signed [MOM_WIDTH-1:0] mc [3];
  logic signed [CW+MOM_WIDTH:0]  pcnl [3];
  logic signed [CW+MOM_WIDTH:0]  pcnh [3];
  logic signed [2*MOM_WIDTH:0]   pmdl [3];
  logic signed [DW-1:0]          pmdh [3];
  logic        [NW-1:0]        nd;
  logic                        zd;
  logic signed [EW-1:0]        ee [3];
  logic        [NW-1:0]        ne;
  logic                        ze;
  logic        [UW-1:0]        uf [3];
  logic        [2:0]           negf;
  logic        [NW-1:0]        nf;
  logic                        zf;
  logic        [QW:0]          qd [3];
  logic        [DL-1:0]        zdl;
  logic        [DL-1:0]        ndl;

  logic [ZW-1:0]       q0e, q1e, q2e, mg;
  logic [LG_WIDTH-1:0] lgv;
  logic [TR_WIDTH-1:0] qxg, qyg;
  logic [LG_WIDTH-1:0] lgg;
  logic                tsg, zg;
  logic [SQW-1:0]      sqx, sqy;
  logic [2*ROOT_WIDTH-1:0] si;
  logic [ROOT_WIDTH-1:0]   root;
  logic [LG_WIDTH-1:0] lgd [0:SL+1];
  logic [SL+1:0]       tsd;
  logic [SL+1:0]       zsd;

  // advance the whole pipeline unless the output holds an untaken result
  assign en        = !res.valid || res.ready;
  assign trk.ready = en;
  assign res.valid = vld[L-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[L-2:0], trk.valid};
    end
  end

  assign pin[0] = trk.point_x;
  assign pin[1] = trk.point_y;
  assign pin[2] = trk.point_z;
  assign vin[0] = trk.vertex_x;
  assign vin[1] = trk.vertex_y;
  assign vin[2] = trk.vertex_z;
  assign min[0] = trk.mom_x;
  assign min[1] = trk.mom_y;
  assign min[2] = trk.mom_z;

  // stages A to F: point offset, dot product, squared norm, numerator, sign and magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ca[i]   <= CW'(pin[i]) - CW'(vin[i]);
        ma[i]   <= min[i];
        cmb[i]  <= ca[i] * ma[i];
        mmb[i]  <= NW'(ma[i] * ma[i]);
        cb[i]   <= ca[i];
        mb[i]   <= ma[i];
        cc[i]   <= cb[i];
        mc[i]   <= mb[i];
        pcnl[i] <= cc[i] * $signed({1'b0, nc[MOM_WIDTH-1:0]});
        pcnh[i] <= cc[i] * $signed({1'b0, nc[NW-1:MOM_WIDTH]});
        pmdl[i] <= mc[i] * $signed({1'b0, dotc[MOM_WIDTH-1:0]});
        pmdh[i] <= mc[i] * $signed(dotc[DW-1:MOM_WIDTH]);
        ee[i]   <= (EW'(pcnh[i]) <<< MOM_WIDTH) + EW'(pcnl[i])
                 - (EW'(pmdh[i]) <<< MOM_WIDTH) - EW'(pmdl[i]);
        negf[i] <= ee[i][EW-1];
        uf[i]   <= ee[i][EW-1] ? UW'(-ee[i]) : UW'(ee[i]);
      end
      dotc <= DW'(cmb[0]) + DW'(cmb[1]) + DW'(cmb[2]);
      nc   <= mmb[0] + mmb[1] + mmb[2];
      zc   <= (mb[0] == '0) && (mb[1] == '0) && (mb[2] == '0);
      nd   <= nc;
      zd   <= zc;
      ne   <= nd;
      ze   <= zd;
      nf   <= ne;
      zf   <= ze;
    end
  end

  // one rounding divider per offset component
  for (genvar i = 0; i < 3; i++) begin : g_div
    cav_div #(
      .NW (NW),
      .QW (QW)
    ) u_div (
      .clk (clk),
      .en  (en),
      .u   (uf[i]),
      .n   (nf),
      .q   (qd[i])
    );
  end

  // carry the flags alongside the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      zdl <= {zdl[DL-2:0], zf};
      ndl <= {ndl[DL-2:0], negf[2]};
    end
  end

  // stage G: saturation checks and longitudinal result
  assign q0e = ZW'(qd[0]);
  assign q1e = ZW'(qd[1]);
  assign q2e = ZW'(qd[2]);
  assign mg  = (q2e > ZW'(LG_MIN_MAG)) ? ZW'(LG_MIN_MAG) : q2e;

  always_comb begin
    if (ndl[DL-1]) begin
      lgv = (q2e > ZW'(LG_MAX)) ? LG_MAX : LG_WIDTH'(q2e);
    end else begin
      lgv = LG_WIDTH'(-mg);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qxg <= TR_WIDTH'(q0e);
      qyg <= TR_WIDTH'(q1e);
      tsg <= (q0e > ZW'(TR_MAX)) || (q1e > ZW'(TR_MAX));
      lgg <= lgv;
      zg  <= zdl[DL-1];
    end
  end

  // stages H and I: squares and their sum
  always_ff @(posedge clk) begin
    if (en) begin
      sqx <= qxg * qxg;
      sqy <= qyg * qyg;
      si  <= (2*ROOT_WIDTH)'(sqx) + (2*ROOT_WIDTH)'(sqy);
    end
  end

  cav_sqrt #(
    .RW (ROOT_WIDTH)
  ) u_sqrt (
    .clk  (clk),
    .en   (en),
    .s    (si),
    .root (root)
  );

  // carry the side results alongside the squares and the root
  always_ff @(posedge clk) begin
    if (en) begin
      lgd[0] <= lgg;
      for (int k = 1; k <= SL + 1; k++) begin
        lgd[k] <= lgd[k-1];
      end
      tsd <= {tsd[SL:0], tsg};
      zsd <= {zsd[SL:0], zg};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      if (zsd[SL+1]) begin
        res.dist_transverse   <= '0;
        res.dist_longitudinal <= '0;
        res.zero_momentum     <= 1'b1;
      end else begin
        if (tsd[SL+1] || (root > ROOT_WIDTH'(TR_MAX))) begin
          res.dist_transverse <= TR_MAX;
        end else begin
          res.dist_transverse <= TR_WIDTH'(root);
        end
        res.dist_longitudinal <= lgd[SL+1];
        res.zero_momentum     <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/cav_checker.sv
// ----------------------------------------------------------------------------
// cav_checker
// Port-level checks on the closest-approach block, bound to its top level.
// ----------------------------------------------------------------------------
module cav_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [cav_pkg::TR_WIDTH-1:0]  dist_transverse,
  input logic [cav_pkg::LG_WIDTH-1:0]  dist_longitudinal,
  input logic                          zero_momentum
);
  import cav_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(dist_transverse)
      && $stable(dist_longitudinal) && $stable(zero_momentum))
    else $error("stalled result changed");

  // zero momentum forces both distances to zero
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_momentum |-> dist_transverse == '0 && dist_longitudinal == '0)
    else $error("zero momentum with nonzero distance");

  // input is taken exactly when the output can move
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output side");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind closest_approach_to_vertex_top cav_checker u_cav_checker (
  .clk               (clk),
  .rst               (rst),
  .in_ready          (trk.ready),
  .out_valid         (res.valid),
  .out_ready         (res.ready),
  .dist_transverse   (res.dist_transverse),
  .dist_longitudinal (res.dist_longitudinal),
  .zero_momentum     (res.zero_momentum)
);

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Closest-approach-to-vertex block: directed and random tracks are sent,
// each transfer is predicted in exact integer arithmetic, and every result
// is checked in order, field by field, against the predicted distances.
// ----------------------------------------------------------------------------
module testbench;
  import cav_pkg::*;

  localparam int PW = POS_WIDTH_DEF;
  localparam int MW = MOM_WIDTH_DEF;
  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic signed [PW-1:0] px, py, pz;
    logic signed [MW-1:0] mx, my, mz;
    logic signed [PW-1:0] vx, vy, vz;
  } track_t;

  typedef struct {
    logic        [TR_WIDTH-1:0] tr;
    logic signed [LG_WIDTH-1:0] lg;
    logic                       zm;
  } dist_t;

  // Predicts closest-approach distances and holds them in arrival order
  class dist_scoreboard;
    dist_t pending[$];
    int errors = 0;

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function longint round_div(longint mag, longint n);
      return (2 * mag + n) / (2 * n);
    endfunction

    function longint floor_root(longint s);
      longint r;
      longint b;
      r = 0;
      for (b = longint'(1) << 22; b != 0; b = b >> 1)
        if ((r + b) * (r + b) <= s) r += b;
      return r;
    endfunction

    function void note_track(track_t t);
      longint c[3], m[3], e[3], q[3];
      longint n, dot, root;
      dist_t d;
      c[0] = longint'(t.px) - longint'(t.vx);
      c[1] = longint'(t.py) - longint'(t.vy);
      c[2] = longint'(t.pz) - longint'(t.vz);
      m[0] = t.mx;
      m[1] = t.my;
      m[2] = t.mz;
      n = 0;
      dot = 0;
      for (int i = 0; i < 3; i++) begin
        n += m[i] * m[i];
        dot += c[i] * m[i];
      end
      if (n == 0) begin
        d.tr = '0;
        d.lg = '0;
        d.zm = 1'b1;
      end else begin
        for (int i = 0; i < 3; i++) begin
          e[i] = c[i] * n - m[i] * dot;
          q[i] = round_div(e[i] < 0 ? -e[i] : e[i], n);
        end
        // Saturate the transverse root
        if (q[0] > longint'(TR_MAX) || q[1] > longint'(TR_MAX)) begin
          d.tr = TR_MAX;
        end else begin
          root = floor_root(q[0] * q[0] + q[1] * q[1]);
          d.tr = root > longint'(TR_MAX) ? TR_MAX : root[TR_WIDTH-1:0];
        end
        // Longitudinal offset is the negated z offset, clamped
        if (e[2] < 0)
          d.lg = LG_WIDTH'(q[2] > longint'(LG_MAX) ? longint'(LG_MAX) : q[2]);
        else
          d.lg = LG_WIDTH'(q[2] > longint'(LG_MIN_MAG) ? -longint'(LG_MIN_MAG) : -q[2]);
        d.zm = 1'b0;
      end
      pending.push_back(d);
    endfunction

    task check_result(dist_t got);
      dist_t w;
      if (pending.size() == 0) begin
        report("result with nothing outstanding");
        return;
      end
      w = pending.pop_front();
      if (got.tr !== w.tr) report($sformatf("transverse %0d, want %0d", got.tr, w.tr));
      if (got.lg !== w.lg) report($sformatf("longitudinal %0d, want %0d", got.lg, w.lg));
      if (got.zm !== w.zm) report($sformatf("zero flag %0b, want %0b", got.zm, w.zm));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  int src_idle = 16;
  int snk_idle = 72;
  int quiet = 0;
  dist_scoreboard sb = new();

  cav_in_if  trk_if ();
  cav_out_if res_if ();

  closest_approach_to_vertex_top u_dut (
    .clk (clk),
    .rst (rst),
    .trk (trk_if),
    .res (res_if)
  );

  always #10 clk = ~clk;

  // Record accepted tracks and check results on each transfer
  always @(posedge clk) begin
    if (!rst && trk_if.valid && trk_if.ready)
      sb.note_track('{trk_if.point_x, trk_if.point_y, trk_if.point_z,
                      trk_if.mom_x, trk_if.mom_y, trk_if.mom_z,
                      trk_if.vertex_x, trk_if.vertex_y, trk_if.vertex_z});
    if (!rst && res_if.valid && res_if.ready)
      sb.check_result('{res_if.dist_transverse, res_if.dist_longitudinal,
                        res_if.zero_momentum});
  end

  // Stall the result side at random
  always @(posedge clk) begin
    res_if.ready <= ($urandom_range(99) >= snk_idle);
  end

  // Abort when no transfer happens for too long
  always @(posedge clk) begin
    if ((trk_if.valid && trk_if.ready) || (res_if.valid && res_if.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic send_track(track_t t);
    while ($urandom_range(99) < src_idle) begin
      trk_if.valid <= 1'b0;
      @(posedge clk);
    end
    trk_if.valid    <= 1'b1;
    trk_if.point_x  <= t.px;
    trk_if.point_y  <= t.py;
    trk_if.point_z  <= t.pz;
    trk_if.mom_x    <= t.mx;
    trk_if.mom_y    <= t.my;
    trk_if.mom_z    <= t.mz;
    trk_if.vertex_x <= t.vx;
    trk_if.vertex_y <= t.vy;
    trk_if.vertex_z <= t.vz;
    do @(posedge clk); while (!trk_if.ready);
  endtask

  task automatic wait_drained();
    trk_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  function automatic logic signed [PW-1:0] near_pos(logic signed [PW-1:0] base, int span);
    return PW'(base + $urandom_range(2 * span) - span);
  endfunction

  function automatic track_t random_track();
    track_t t;
    int kind;
    kind = $urandom_range(99);
    t.vx = PW'($urandom);
    t.vy = PW'($urandom);
    t.vz = PW'($urandom);
    t.mx = MW'($urandom);
    t.my = MW'($urandom);
    t.mz = MW'($urandom);
    if (kind < 60) begin
      // track passing near the vertex, distances stay in range
      t.px = near_pos(t.vx, 4096);
      t.py = near_pos(t.vy, 4096);
      t.pz = near_pos(t.vz, 4096);
      if (kind < 20) begin
        t.mx = MW'($urandom_range(400) - 200);
        t.my = MW'($urandom_range(400) - 200);
        t.mz = MW'($urandom_range(400) - 200);
      end
    end else begin
      t.px = PW'($urandom);
      t.py = PW'($urandom);
      t.pz = PW'($urandom);
    end
    if (kind >= 94) begin
      t.mx = '0;
      t.my = '0;
      t.mz = '0;
    end else if (kind >= 88) begin
      // momentum along a single axis, or none at all
      if (kind != 88) t.mx = '0;
      if (kind != 90) t.my = '0;
      if (kind != 92) t.mz = '0;
    end
    return t;
  endfunction

  localparam logic signed [PW-1:0] PMAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] PMIN = {1'b1, {(PW-1){1'b0}}};
  localparam logic signed [MW-1:0] MMAX = {1'b0, {(MW-1){1'b1}}};
  localparam logic signed [MW-1:0] MMIN = {1'b1, {(MW-1){1'b0}}};

  initial begin
    track_t directed[$];
    int n_rand;
    rst <= 1'b1;
    trk_if.valid <= 1'b0;
    trk_if.point_x <= '0;
    trk_if.point_y <= '0;
    trk_if.point_z <= '0;
    trk_if.mom_x <= '0;
    trk_if.mom_y <= '0;
    trk_if.mom_z <= '0;
    trk_if.vertex_x <= '0;
    trk_if.vertex_y <= '0;
    trk_if.vertex_z <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Zero momentum, single-axis tracks, extremes and the largest offsets
    directed.push_back('{100, 200, 300, 0, 0, 0, 0, 0, 0});
    directed.push_back('{PMAX, PMIN, PMAX, 0, 0, 0, PMIN, PMAX, PMIN});
    directed.push_back('{1024, 0, 0, 0, 0, 1, 0, 0, 0});
    directed.push_back('{0, 0, 5000, 1, 0, 0, 0, 0, 0});
    directed.push_back('{0, 0, -5000, -1, 0, 0, 0, 0, 0});
    directed.push_back('{PMAX, PMAX, PMAX, MMAX, MMAX, MMAX, PMIN, PMIN, PMIN});
    directed.push_back('{PMIN, PMIN, PMIN, MMIN, MMIN, MMIN, PMAX, PMAX, PMAX});
    directed.push_back('{PMAX, PMIN, 0, 0, 0, MMAX, PMIN, PMAX, 0});
    directed.push_back('{0, 0, PMAX, MMAX, 0, 0, 0, 0, PMIN});
    directed.push_back('{0, 0, PMIN, MMIN, 0, 0, 0, 0, PMAX});
    directed.push_back('{1, 0, 0, 1, 1, 0, 0, 0, 0});
    directed.push_back('{3, 1, 1, 1, 1, 1, 0, 0, 0});
    directed.push_back('{PMAX, PMAX, PMAX, MMAX, MMIN, 1, 0, 0, 0});
    directed.push_back('{-7, 9, 11, MMIN, MMAX, MMIN, 5, -3, 2});
    foreach (directed[i]) send_track(directed[i]);

    n_rand = 536;
    for (int ph = 0; ph < 3; ph++) begin
      // hold the sender until every pending result has come back
      wait_drained();
      if (ph == 1) begin
        src_idle = 72;
        snk_idle = 16;
      end else if (ph == 2) begin
        src_idle = 0;
        snk_idle = 0;
      end
      for (int i = 0; i < n_rand / 3; i++) send_track(random_track());
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/cav_pkg.sv
rtl/core/cav_if.sv
rtl/core/cav_div.sv
rtl/core/cav_sqrt.sv
rtl/core/closest_approach_to_vertex_top.sv
rtl/core/cav_checker.sv
dv/testbench.sv
